[hw/rtl/rrbc_pkg.sv]
`default_nettype none

package rrbc_pkg;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned MAX_RAM_BANKS  = 4;
  localparam int unsigned MAX_ROM_BANKS  = 128;

  localparam int unsigned ROM_OFS_W   = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W   = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_BANK_W  = $clog2(MAX_ROM_BANKS);
  localparam int unsigned RAM_BANK_W  = $clog2(MAX_RAM_BANKS);
  localparam int unsigned RAM_DEPTH   = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int unsigned RAM_IDX_W   = $clog2(RAM_DEPTH);
  localparam int unsigned ROM_ADDR_W  = 21;

  localparam logic [7:0] OPEN_BUS     = 8'hFF;
  localparam logic [3:0] RAM_EN_KEY   = 4'hA;

  // configuration register indexes
  localparam logic CFG_ROM_BANKS = 1'b0;
  localparam logic CFG_RAM_BANKS = 1'b1;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  // address regions by the top three address bits
  typedef enum logic [2:0] {
    RGN_RAM_EN    = 3'd0,
    RGN_ROM_LOW   = 3'd1,
    RGN_BANK_HIGH = 3'd2,
    RGN_MODE      = 3'd3,
    RGN_VIDEO     = 3'd4,
    RGN_CART_RAM  = 3'd5,
    RGN_WORK_RAM  = 3'd6,
    RGN_HIGH      = 3'd7
  } region_e;

  typedef struct packed {
    logic [7:0] rom_bank_count;
    logic [2:0] ram_bank_count;
    logic       ram_enabled;
    logic [4:0] rom_bank_low;
    logic [1:0] bank_high;
    logic       advanced_mode;
  } bank_state_t;

  typedef struct packed {
    kind_e                   kind;
    logic [ROM_ADDR_W-1:0]   rom_address;
    logic                    ram_rd;
    logic                    ram_wr;
    logic [RAM_IDX_W-1:0]    ram_idx;
  } map_res_t;

  // next power of two of count, minus one
  function automatic logic [7:0] pow2_mask(input logic [7:0] count);
    logic [7:0] m;
    if (count == 8'd0) begin
      m = 8'd0;
    end else begin
      m = count - 8'd1;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rrbc_regs.sv]
`default_nettype none

module rrbc_regs (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               wr_en_i,
  input  wire logic [15:0]        wr_addr_i,
  input  wire logic [7:0]         wr_data_i,
  output rrbc_pkg::bank_state_t   state_o
);
  import rrbc_pkg::*;

  bank_state_t state_q, state_d;
  region_e     rgn;

  assign rgn = region_e'(wr_addr_i[15:13]);

  always_comb begin
    state_d = state_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROM_BANKS: state_d.rom_bank_count = cfg_data_i;
        CFG_RAM_BANKS: state_d.ram_bank_count = cfg_data_i[2:0];
        default:       state_d = state_q;
      endcase
    end
    if (wr_en_i) begin
      unique case (rgn)
        RGN_RAM_EN:    state_d.ram_enabled   = (wr_data_i[3:0] == RAM_EN_KEY);
        RGN_ROM_LOW:   state_d.rom_bank_low  = (wr_data_i[4:0] == 5'd0) ? 5'd1
                                                                          : wr_data_i[4:0];
        RGN_BANK_HIGH: state_d.bank_high     = wr_data_i[1:0];
        RGN_MODE:      state_d.advanced_mode = wr_data_i[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.rom_bank_count <= 8'd2;
      state_q.ram_bank_count <= 3'd0;
      state_q.ram_enabled    <= 1'b0;
      state_q.rom_bank_low   <= 5'd1;
      state_q.bank_high      <= 2'd0;
      state_q.advanced_mode  <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

[hw/rtl/rrbc_map.sv]
`default_nettype none

module rrbc_map (
  input  wire logic               is_write_i,
  input  wire logic [15:0]        addr_i,
  input  rrbc_pkg::bank_state_t   state_i,
  output rrbc_pkg::map_res_t      res_o
);
  import rrbc_pkg::*;

  logic [7:0]            eff_rom;
  logic [7:0]            rom_mask;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [ROM_BANK_W-1:0] sw_bank;
  logic                  rom_oob;
  logic [2:0]            eff_ram;
  logic [7:0]            ram_mask;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic                  ram_ok;
  logic                  in_ram_win;

  always_comb begin
    eff_rom  = (state_i.rom_bank_count > 8'(MAX_ROM_BANKS)) ? 8'(MAX_ROM_BANKS)
                                                            : state_i.rom_bank_count;
    rom_mask = pow2_mask(eff_rom);
    sw_bank  = {state_i.bank_high, state_i.rom_bank_low} & rom_mask[ROM_BANK_W-1:0];
    if (!addr_i[14]) begin
      rom_bank = state_i.advanced_mode
               ? ({state_i.bank_high, 5'd0} & rom_mask[ROM_BANK_W-1:0])
               : '0;
    end else begin
      // bank zero cannot be mapped into the switchable window
      rom_bank = (sw_bank == '0) ? ROM_BANK_W'(1) : sw_bank;
    end
    // offset stays below one bank, so the bound reduces to the bank number
    rom_oob = ({1'b0, rom_bank} >= eff_rom);

    eff_ram  = (state_i.ram_bank_count > 3'(MAX_RAM_BANKS)) ? 3'(MAX_RAM_BANKS)
                                                            : state_i.ram_bank_count;
    ram_mask = pow2_mask({5'd0, eff_ram});
    ram_bank = state_i.advanced_mode ? (state_i.bank_high & ram_mask[RAM_BANK_W-1:0]) : '0;
    ram_ok   = (eff_ram != 3'd0) && state_i.ram_enabled
            && ({1'b0, ram_bank} < eff_ram);
    in_ram_win = (region_e'(addr_i[15:13]) == RGN_CART_RAM);

    res_o.rom_address = '0;
    res_o.ram_rd      = 1'b0;
    res_o.ram_wr      = 1'b0;
    res_o.ram_idx     = {ram_bank, addr_i[RAM_OFS_W-1:0]};
    if (is_write_i) begin
      res_o.kind   = KIND_WRITE;
      res_o.ram_wr = in_ram_win && ram_ok;
    end else if (!addr_i[15]) begin
      if (rom_oob) begin
        res_o.kind = KIND_DATA;
      end else begin
        res_o.kind        = KIND_ROM;
        res_o.rom_address = ROM_ADDR_W'({rom_bank, addr_i[ROM_OFS_W-1:0]});
      end
    end else begin
      res_o.kind   = KIND_DATA;
      res_o.ram_rd = in_ram_win && ram_ok;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rrbc_ram.sv]
`default_nettype none

module rrbc_ram (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [rrbc_pkg::RAM_IDX_W-1:0] wr_idx_i,
  input  wire logic [7:0]                     wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [rrbc_pkg::RAM_IDX_W-1:0] rd_idx_i,
  output logic [7:0]                          rd_data_o,
  output logic                                busy_o
);
  import rrbc_pkg::*;

  logic [7:0]           mem [RAM_DEPTH];
  logic [RAM_IDX_W-1:0] clr_idx_q;
  logic                 busy_q;
  logic [7:0]           rd_data_q;
  logic                 we;
  logic [RAM_IDX_W-1:0] widx;
  logic [7:0]           wdata;

  // zero sweep after reset, one byte a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      clr_idx_q <= clr_idx_q + RAM_IDX_W'(1);
      if (clr_idx_q == '1) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign we    = busy_q || wr_en_i;
  assign widx  = busy_q ? clr_idx_q : wr_idx_i;
  assign wdata = busy_q ? 8'd0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[widx] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

[hw/rtl/rom_ram_bank_controller.sv]
// channel | handshake                      | payload
// in      | in_valid_i / in_stall_o        | req_type_i, address_i, write_data_i
// out     | out_valid_o / out_stall_i      | result_kind_o, rom_address_o, read_data_o
// cfg     | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while out_stall_i is low; each item passes the input
// register, then mapping and the ram port into the result register.
// after reset the cart ram is swept to zero, with in_stall_o high until the sweep is done.
// a stalled result holds while one more item waits in the input register.
// config writes are taken in every cycle, cfg_ready_o stays high.
`default_nettype none

module rom_ram_bank_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             req_type_i,
  input  wire logic [15:0]                      address_i,
  input  wire logic [7:0]                       write_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            result_kind_o,
  output logic [rrbc_pkg::ROM_ADDR_W-1:0]       rom_address_o,
  output logic [7:0]                            read_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_index_i,
  input  wire logic [7:0]                       cfg_data_i
);
  import rrbc_pkg::*;

  logic                  s1_valid_q;
  logic                  s1_write_q;
  logic [15:0]           s1_addr_q;
  logic [7:0]            s1_data_q;
  logic                  s1_adv;
  logic                  in_acc;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [ROM_ADDR_W-1:0] out_rom_q;
  logic                  out_hit_q;
  logic [7:0]            out_data_q;

  bank_state_t           bank_state;
  map_res_t              map_res;
  logic [7:0]            ram_rdata;
  logic                  ram_busy;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = ram_busy || (s1_valid_q && !s1_adv);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_write_q <= req_type_i;
      s1_addr_q  <= address_i;
      s1_data_q  <= write_data_i;
    end
  end

  rrbc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_i     (s1_adv && s1_write_q),
    .wr_addr_i   (s1_addr_q),
    .wr_data_i   (s1_data_q),
    .state_o     (bank_state)
  );

  rrbc_map u_map (
    .is_write_i (s1_write_q),
    .addr_i     (s1_addr_q),
    .state_i    (bank_state),
    .res_o      (map_res)
  );

  rrbc_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s1_adv && map_res.ram_wr),
    .wr_idx_i  (map_res.ram_idx),
    .wr_data_i (s1_data_q),
    .rd_en_i   (s1_adv && map_res.ram_rd),
    .rd_idx_i  (map_res.ram_idx),
    .rd_data_o (ram_rdata),
    .busy_o    (ram_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q <= map_res.kind;
      out_rom_q  <= map_res.rom_address;
      out_hit_q  <= map_res.ram_rd;
      // open bus for failed reads, zero where the byte means nothing
      out_data_q <= (map_res.kind == KIND_DATA) ? OPEN_BUS : 8'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign rom_address_o = out_rom_q;
  assign read_data_o   = out_hit_q ? ram_rdata : out_data_q;

endmodule

`default_nettype wire

[hw/rtl/rrbc_checker.sv]
`default_nettype none

module rrbc_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_stall_o,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  input  wire logic [1:0]                       result_kind_o,
  input  wire logic [rrbc_pkg::ROM_ADDR_W-1:0]  rom_address_o,
  input  wire logic [7:0]                       read_data_o
);
  import rrbc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(rom_address_o) && $stable(read_data_o))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o == KIND_ROM || result_kind_o == KIND_DATA
      || result_kind_o == KIND_WRITE)
    else $error("illegal result kind");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o == KIND_ROM || read_data_o == 8'd0 || result_kind_o == KIND_DATA)
      && (result_kind_o == KIND_ROM || rom_address_o == '0))
    else $error("unused result field not zero");

  // a result only appears once an accepted item has passed the input register into the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an accepted item");

endmodule

bind rom_ram_bank_controller rrbc_checker u_rrbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_kind_o (result_kind_o),
  .rom_address_o (rom_address_o),
  .read_data_o   (read_data_o)
);

`default_nettype wire
